// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands. Each macro samples on clk_i and is disabled while
// rst_ni is low, so the module that uses them must have both signals.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold in every cycle.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A condition that implies a consequence in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A condition that implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/slid_pkg.sv =====
// ---------------------------------------------------------------------------
// slid_pkg
// Types, codes and defaults shared by the sorted list core and its cells.
// ---------------------------------------------------------------------------
package slid_pkg;

  localparam int CAPACITY_DEF = 128;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic               action;
    logic signed [31:0] value;
  } slid_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] position;
    logic [7:0] entry_count;
  } slid_out_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic find_ins;  // flag marks first entry not below value, else equal entry
    logic ins_en;    // commit an insert at the found position
    logic del_en;    // commit a delete at the found position
  } slid_cell_ctrl_t;

endpackage

// ===== src/slid_cell.sv =====
// ---------------------------------------------------------------------------
// slid_cell
// One storage cell of the sorted list: holds one entry, compares it with the
// item value and shifts in its neighbor's entry when the list moves.
// ---------------------------------------------------------------------------
module slid_cell import slid_pkg::*; #(
  parameter int IDX_W = 7,
  parameter int CNT_W = 8,
  parameter int INDEX = 0
) (
  input  logic               clk_i,
  input  slid_cell_ctrl_t    ctrl_i,
  input  logic signed [31:0] value_i,
  input  logic [CNT_W-1:0]   count_i,
  input  logic [IDX_W-1:0]   pos_i,
  input  logic signed [31:0] prev_i,
  input  logic signed [31:0] next_i,
  output logic signed [31:0] entry_o,
  output logic               flag_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

  logic signed [31:0] entry_q;
  logic               held;

  assign held    = MY_CNT < count_i;
  assign entry_o = entry_q;

  always_comb begin
    if (ctrl_i.find_ins) begin
      flag_o = !(held && (entry_q < value_i));
    end else begin
      flag_o = held && (entry_q == value_i);
    end
  end

  // On insert the cells above the slot take their lower neighbor; on delete
  // the removed slot and everything above it take their upper neighbor.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins_en) begin
      if (MY_IDX == pos_i) begin
        entry_q <= value_i;
      end else if (MY_IDX > pos_i) begin
        entry_q <= prev_i;
      end
    end else if (ctrl_i.del_en && (MY_IDX >= pos_i)) begin
      entry_q <= next_i;
    end
  end

endmodule

// ===== src/slid_find_first.sv =====
// ---------------------------------------------------------------------------
// slid_find_first
// Registered binary tree that returns the lowest index whose flag is set.
// Every tree level, leaves included, is a register stage.
// ---------------------------------------------------------------------------
module slid_find_first import slid_pkg::*; #(
  parameter int N     = CAPACITY_DEF,
  parameter int IDX_W = 7
) (
  input  logic             clk_i,
  input  logic [N-1:0]     flags_i,
  output logic             found_o,
  output logic [IDX_W-1:0] index_o
);

  localparam int LEAVES     = 2 ** IDX_W;
  localparam int NODES      = 2 * LEAVES - 1;
  localparam int FIRST_LEAF = LEAVES - 1;

  logic [LEAVES-1:0] flags_pad;
  logic              fnd_q [NODES];
  logic [IDX_W-1:0]  idx_q [NODES];

  assign flags_pad = LEAVES'(flags_i);

  // Heap layout: node n has children 2n+1 and 2n+2, the root is node 0.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LEAVES; i++) begin
      fnd_q[FIRST_LEAF + i] <= flags_pad[i];
      idx_q[FIRST_LEAF + i] <= IDX_W'(i);
    end
    for (int n = 0; n < FIRST_LEAF; n++) begin
      fnd_q[n] <= fnd_q[2 * n + 1] | fnd_q[2 * n + 2];
      idx_q[n] <= fnd_q[2 * n + 1] ? idx_q[2 * n + 1] : idx_q[2 * n + 2];
    end
  end

  assign found_o = fnd_q[0];
  assign index_o = idx_q[0];

endmodule

// ===== src/sorted_list_insert_delete_core.sv =====
// ---------------------------------------------------------------------------
// sorted_list_insert_delete_core
// Sorted list of signed 32-bit values held in a row of cells, with insert in
// order and delete of the first equal value.
//
//   Channel | Signals                           | Beat
//   --------+-----------------------------------+-------------------------
//   in      | in_valid_i, in_stall_o, in_data_i | one insert or delete
//   out     | out_valid_o, out_stall_i, out_data_o | status, position, count
//
// An item passes through the register stages of the find-first tree over
// the cells between acceptance and its result; the next item is taken in
// the cycle after the result is registered.
// Reset clears the entry count and the control state; cell contents are
// not cleared and are never read at or above the count.
// A result stalled on the output holds the next item in its final step.
// ---------------------------------------------------------------------------
module sorted_list_insert_delete_core import slid_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  slid_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output slid_out_t out_data_o
);

`include "assert_macros.svh"

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int STEP_W = $clog2(IDX_W + 2);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(IDX_W + 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(CAPACITY);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SRCH = 1'b1;

  logic               state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               action_q;
  logic signed [31:0] value_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               out_valid_q, out_valid_d;
  slid_out_t          out_data_q, out_data_d;

  logic               in_accept;
  logic               search_done;
  logic               apply;
  logic               is_ins;
  logic               full;
  logic               root_fnd;
  logic [IDX_W-1:0]   root_idx;
  slid_cell_ctrl_t    cell_ctrl;
  logic [CAPACITY-1:0] flags;
  logic signed [31:0] entry_w [CAPACITY];

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign search_done = (state_q == S_SRCH) && (step_q == LAST_STEP);
  assign apply       = search_done && (!out_valid_q || !out_stall_i);
  assign is_ins      = (action_q == ACT_INSERT);
  assign full        = (count_q == FULL_CNT);

  assign cell_ctrl.find_ins = is_ins;
  assign cell_ctrl.ins_en   = apply && is_ins && !full;
  assign cell_ctrl.del_en   = apply && !is_ins && root_fnd;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] prev_w;
    logic signed [31:0] next_w;
    if (i == 0) begin : g_first
      assign prev_w = value_q;
    end else begin : g_mid_lo
      assign prev_w = entry_w[i - 1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = entry_w[i];
    end else begin : g_mid_hi
      assign next_w = entry_w[i + 1];
    end
    slid_cell #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .value_i (value_q),
      .count_i (count_q),
      .pos_i   (root_idx),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .entry_o (entry_w[i]),
      .flag_o  (flags[i])
    );
  end

  slid_find_first #(
    .N     (CAPACITY),
    .IDX_W (IDX_W)
  ) u_find (
    .clk_i   (clk_i),
    .flags_i (flags),
    .found_o (root_fnd),
    .index_o (root_idx)
  );

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_SRCH;
          step_d  = '0;
        end
      end
      S_SRCH: begin
        if (!search_done) begin
          step_d = step_q + 1'b1;
        end else if (apply) begin
          state_d = S_IDLE;
          out_valid_d = 1'b1;
          if (cell_ctrl.ins_en) begin
            count_d = count_q + 1'b1;
            out_data_d.status   = ST_DONE;
            out_data_d.position = 7'(root_idx);
          end else if (cell_ctrl.del_en) begin
            count_d = count_q - 1'b1;
            out_data_d.status   = ST_DONE;
            out_data_d.position = 7'(root_idx);
          end else begin
            out_data_d.status   = is_ins ? ST_FULL : ST_MISS;
            out_data_d.position = '0;
          end
          out_data_d.entry_count = 8'(count_d);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    if (in_accept) begin
      action_q <= in_data_i.action;
      value_q  <= in_data_i.value;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASSERT_ALWAYS(a_count_bound, count_q <= FULL_CNT, "entry count above capacity")
  `ASSERT_NEXT(a_accept_starts, in_accept, (state_q == S_SRCH) && (step_q == '0),
               "accepted item did not start a search")
  `ASSERT_IMPLIES(a_ins_slot, apply && is_ins && !full, root_fnd,
                  "insert into a list with room found no slot")
  `ASSERT_NEXT(a_ins_count, cell_ctrl.ins_en, count_q == $past(count_q) + 1'b1,
               "insert did not grow the count by one")

endmodule
